### hdl/stereo_haas_surround_macros.svh
// Assertion helpers shared by the surround block RTL
`ifndef STEREO_HAAS_SURROUND_MACROS_SVH
`define STEREO_HAAS_SURROUND_MACROS_SVH

// Clocked check, switched off while reset is held
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is held
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/shs_pkg.sv
package shs_pkg;

  // Sample and coefficient formats
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COEF_W  = 31;
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned BAL_W   = 7;
  localparam int unsigned DELAY_W = 10;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Default store depth (a power of two)
  localparam int unsigned MAX_DELAY_DEPTH_DEF = 1024;

  // Register port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_LOW_CUT   = 3'd0,
    REG_HIGH_CUT  = 3'd1,
    REG_BASS      = 3'd2,
    REG_TREBLE    = 3'd3,
    REG_DELAY_SEL = 3'd4,
    REG_BALANCE   = 3'd5,
    REG_ALTER     = 3'd6
  } reg_idx_e;

  // Delay selector codes
  localparam logic [SEL_W-1:0] DSEL_91  = 3'd1;
  localparam logic [SEL_W-1:0] DSEL_182 = 3'd2;
  localparam logic [SEL_W-1:0] DSEL_454 = 3'd3;
  localparam logic [SEL_W-1:0] DSEL_727 = 3'd4;
  localparam logic [SEL_W-1:0] DSEL_909 = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] low_cut;
    logic [COEF_W-1:0] high_cut;
    logic [COEF_W-1:0] bass;
    logic [COEF_W-1:0] treble;
    logic [SEL_W-1:0]  delay_sel;
    logic [BAL_W-1:0]  balance;
    logic              alter;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    low_cut:   31'd15582647,
    high_cut:  31'd165565620,
    bass:      31'd7791323,
    treble:    31'd331131240,
    delay_sel: DSEL_909,
    balance:   7'd0,
    alter:     1'b0
  };

  // Division by 200 as a shift by 3 and a reciprocal multiply for 25
  localparam int unsigned MAG_W     = 29;
  localparam int unsigned RECIP_W   = 30;
  localparam int unsigned RPROD_W   = MAG_W + RECIP_W;
  localparam int unsigned QUOT_W    = 25;
  localparam logic [RECIP_W-1:0] RECIP_25 = 30'd687194768;

  // Pipeline depth from input register to output register
  localparam int unsigned PIPE_STAGES = 11;

  // Signed Q31 product, rounded toward minus infinity
  function automatic sample_t fracmul(input sample_t a, input logic [COEF_W-1:0] c);
    logic signed [2*DATA_W-2:0] p;
    p = a * $signed({1'b0, c});
    return p[2*DATA_W-2:DATA_W-1];
  endfunction

  // Halve, truncating toward zero
  function automatic sample_t half_tz(input sample_t v);
    sample_t s;
    s = v + $signed({{(DATA_W-1){1'b0}}, v[DATA_W-1]});
    return s >>> 1;
  endfunction

  // Nominal delay in samples for a selector code
  function automatic logic [DELAY_W-1:0] delay_of(input logic [SEL_W-1:0] sel);
    logic [DELAY_W-1:0] d;
    case (sel)
      DSEL_91:  d = 10'd91;
      DSEL_182: d = 10'd182;
      DSEL_454: d = 10'd454;
      DSEL_727: d = 10'd727;
      default:  d = 10'd909;
    endcase
    return d;
  endfunction

endpackage

### hdl/stereo_haas_surround.sv
// Throughput: one frame per cycle while the output is not stalled; the eleven-stage
// chain (two dependent Q31 multiplies and the divide-by-200 reciprocal multiply)
// sets the pipeline depth from an input transfer to the output register.
// Each delay store is one RAM with one write and one registered read per cycle.
// Reset clears control, write position and fill count; store contents are kept,
// and entries older than the last reset or flush read as zero via the fill count.
`include "stereo_haas_surround_macros.svh"

module stereo_haas_surround #(
  parameter int unsigned MAX_DELAY_DEPTH = shs_pkg::MAX_DELAY_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  shs_pkg::sample_t            left_in_i,
  input  shs_pkg::sample_t            right_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output shs_pkg::sample_t            left_out_o,
  output shs_pkg::sample_t            right_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [shs_pkg::APB_AW-1:0]  paddr,
  input  logic [shs_pkg::APB_DW-1:0]  pwdata,
  output logic [shs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned NST         = shs_pkg::PIPE_STAGES;
  localparam int unsigned POS_W       = $clog2(MAX_DELAY_DEPTH);
  localparam int unsigned CNT_W       = POS_W + 1;
  localparam int unsigned DEPTH_LOW   = MAX_DELAY_DEPTH / 8;
  localparam int unsigned DEPTH_BASS  = MAX_DELAY_DEPTH / 4;
  localparam int unsigned DEPTH_HIGH  = MAX_DELAY_DEPTH;
  localparam int unsigned DEPTH_TREB  = MAX_DELAY_DEPTH / 2;
  localparam int unsigned AW_LOW      = $clog2(DEPTH_LOW);
  localparam int unsigned AW_BASS     = $clog2(DEPTH_BASS);
  localparam int unsigned AW_HIGH     = $clog2(DEPTH_HIGH);
  localparam int unsigned AW_TREB     = $clog2(DEPTH_TREB);

  typedef struct packed {
    shs_pkg::sample_t y;
    shs_pkg::sample_t mid;
  } side_t;

  // Configuration
  shs_pkg::cfg_t cfg;
  logic          cfg_flush;

  shs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .flush_o (cfg_flush)
  );

  // Stage handshake
  logic [NST:1] v_q, v_d, can;
  logic         acc, out_fire;

  always_comb begin
    can[NST] = !v_q[NST] || out_ready_i;
    for (int i = NST - 1; i >= 1; i--) begin
      can[i] = !v_q[i] || can[i+1];
    end
  end

  always_comb begin
    v_d[1] = can[1] ? in_valid_i : v_q[1];
    for (int i = 2; i <= NST; i++) begin
      v_d[i] = can[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = can[1];
  assign acc         = in_valid_i && can[1];
  assign out_valid_o = v_q[NST];
  assign out_fire    = out_valid_o && out_ready_i;

  // Effective delays, clamped to the store depth
  logic [shs_pkg::DELAY_W-1:0] dly_nom;
  logic [CNT_W-1:0]            dly, dd_low, dd_bass, dd_treb;

  always_comb begin
    dly_nom = shs_pkg::delay_of(cfg.delay_sel);
    if (32'(dly_nom) > MAX_DELAY_DEPTH) begin
      dly = CNT_W'(MAX_DELAY_DEPTH);
    end else begin
      dly = CNT_W'(dly_nom);
    end
    dd_low  = dly >> 3;
    dd_bass = dly >> 2;
    dd_treb = dly >> 1;
  end

  // Write position and count of entries written since the last flush
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      if (acc) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cfg_flush) begin
        fill_q <= '0;
      end else if (acc && (fill_q != CNT_W'(MAX_DELAY_DEPTH))) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Delay stores
  logic                        mem_we;
  logic [shs_pkg::DATA_W-1:0]  rd_low, rd_bass, rd_high, rd_treb;
  logic [shs_pkg::DATA_W-1:0]  wd_low, wd_bass, wd_high, wd_treb;
  logic [POS_W-1:0]            s1_pos_q, s2_pos_q, s2_pos_inc;
  logic [AW_LOW-1:0]           ra_low;
  logic [AW_BASS-1:0]          ra_bass;
  logic [AW_HIGH-1:0]          ra_high;
  logic [AW_TREB-1:0]          ra_treb;

  // Read the entry written the delay ago; a full-depth delay reads the write slot
  assign ra_low  = pos_q[AW_LOW-1:0]  - dd_low[AW_LOW-1:0];
  assign ra_bass = pos_q[AW_BASS-1:0] - dd_bass[AW_BASS-1:0];
  assign ra_high = pos_q[AW_HIGH-1:0] - dly[AW_HIGH-1:0];
  assign ra_treb = pos_q[AW_TREB-1:0] - dd_treb[AW_TREB-1:0];

  shs_delay_ram #(.DEPTH(DEPTH_LOW)) u_ram_low (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (s2_pos_q[AW_LOW-1:0]),
    .wr_data_i (wd_low),
    .rd_en_i   (acc),
    .rd_addr_i (ra_low),
    .rd_data_o (rd_low)
  );

  shs_delay_ram #(.DEPTH(DEPTH_BASS)) u_ram_bass (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (s2_pos_q[AW_BASS-1:0]),
    .wr_data_i (wd_bass),
    .rd_en_i   (acc),
    .rd_addr_i (ra_bass),
    .rd_data_o (rd_bass)
  );

  shs_delay_ram #(.DEPTH(DEPTH_HIGH)) u_ram_high (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (s2_pos_q[AW_HIGH-1:0]),
    .wr_data_i (wd_high),
    .rd_en_i   (acc),
    .rd_addr_i (ra_high),
    .rd_data_o (rd_high)
  );

  shs_delay_ram #(.DEPTH(DEPTH_TREB)) u_ram_treb (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (s2_pos_q[AW_TREB-1:0]),
    .wr_data_i (wd_treb),
    .rd_en_i   (acc),
    .rd_addr_i (ra_treb),
    .rd_data_o (rd_treb)
  );

  // Pipeline registers
  shs_pkg::sample_t s1_l_q, s1_r_q, s1_n_q;
  logic             s1_ok_low_q, s1_ok_bass_q, s1_ok_high_q, s1_ok_treb_q;
  shs_pkg::sample_t s2_r_q, s2_prl_q, s2_prh_q, s2_prb_q, s2_prt_q, s2_pnl_q, s2_pnh_q;
  shs_pkg::sample_t s2_dl_q;
  shs_pkg::sample_t db_q [2:4];
  shs_pkg::sample_t dh_q [2:4];
  shs_pkg::sample_t dt_q [2:6];
  side_t            side_q [2:10];
  shs_pkg::sample_t s3_x_q, s4_x_q, s5_x_q, s6_x_q, s6_t_q, s7_x_q, s8_x_q, s9_x_q;
  shs_pkg::sample_t s10_x_q, s10_mx_q, s10_my_q;
  logic [shs_pkg::MAG_W-1:0]  s8_ax_q, s8_ay_q;
  logic [shs_pkg::QUOT_W-1:0] s9_qx_q, s9_qy_q;
  shs_pkg::sample_t out_l_q, out_r_q;

  // Combinational terms between stages
  shs_pkg::sample_t            x0, x_fin, y_fin, qsx, qsy;
  logic [shs_pkg::DATA_W-1:0]  mag_x, mag_y;
  logic [shs_pkg::RPROD_W-1:0] prod_x, prod_y;

  // Store the band terms as the item leaves the product stage
  assign mem_we     = v_q[2] && can[3];
  assign wd_low     = s2_r_q - s2_prl_q;
  assign wd_bass    = s2_r_q - s2_prb_q;
  assign wd_high    = s2_prh_q;
  assign wd_treb    = s2_prt_q;
  assign s2_pos_inc = s2_pos_q + 1'b1;

  always_comb begin
    // First right-channel term
    if (cfg.alter) begin
      x0 = shs_pkg::half_tz(s2_pnl_q) - shs_pkg::half_tz(s2_pnh_q);
    end else begin
      x0 = s2_prl_q - s2_prh_q;
    end
    // Magnitudes for the divide by 200
    mag_x  = s7_x_q[shs_pkg::DATA_W-1] ? (32'd0 - s7_x_q) : s7_x_q;
    mag_y  = side_q[7].y[shs_pkg::DATA_W-1] ? (32'd0 - side_q[7].y) : side_q[7].y;
    prod_x = shs_pkg::RPROD_W'(s8_ax_q) * shs_pkg::RPROD_W'(shs_pkg::RECIP_25);
    prod_y = shs_pkg::RPROD_W'(s8_ay_q) * shs_pkg::RPROD_W'(shs_pkg::RECIP_25);
    // Signed quotients, truncated toward zero
    qsx = s9_x_q[shs_pkg::DATA_W-1] ? -$signed(32'(s9_qx_q)) : $signed(32'(s9_qx_q));
    qsy = side_q[9].y[shs_pkg::DATA_W-1] ? -$signed(32'(s9_qy_q)) :
                                            $signed(32'(s9_qy_q));
    // Balance and mid mix
    if (cfg.alter) begin
      y_fin = side_q[10].y + s10_my_q + side_q[10].mid;
      x_fin = s10_x_q - s10_mx_q + side_q[10].mid;
    end else begin
      y_fin = side_q[10].y - s10_my_q;
      x_fin = s10_x_q + s10_mx_q;
    end
  end

  // Advance the data stages
  always_ff @(posedge clk_i) begin
    // input register, store reads issued alongside
    if (can[1]) begin
      s1_l_q       <= left_in_i;
      s1_r_q       <= right_in_i;
      s1_n_q       <= right_in_i - left_in_i;
      s1_pos_q     <= pos_q;
      s1_ok_low_q  <= fill_q >= dd_low;
      s1_ok_bass_q <= fill_q >= dd_bass;
      s1_ok_high_q <= fill_q >= dly;
      s1_ok_treb_q <= fill_q >= dd_treb;
    end
    // band products, masked store data, left and mid terms
    if (can[2]) begin
      s2_r_q      <= s1_r_q;
      s2_pos_q    <= s1_pos_q;
      s2_prl_q    <= shs_pkg::fracmul(s1_r_q, cfg.low_cut);
      s2_prh_q    <= shs_pkg::fracmul(s1_r_q, cfg.high_cut);
      s2_prb_q    <= shs_pkg::fracmul(s1_r_q, cfg.bass);
      s2_prt_q    <= shs_pkg::fracmul(s1_r_q, cfg.treble);
      s2_pnl_q    <= shs_pkg::fracmul(s1_n_q, cfg.low_cut);
      s2_pnh_q    <= shs_pkg::fracmul(s1_n_q, cfg.high_cut);
      s2_dl_q     <= s1_ok_low_q  ? $signed(rd_low)  : '0;
      db_q[2]     <= s1_ok_bass_q ? $signed(rd_bass) : '0;
      dh_q[2]     <= s1_ok_high_q ? $signed(rd_high) : '0;
      dt_q[2]     <= s1_ok_treb_q ? $signed(rd_treb) : '0;
      side_q[2].y <= cfg.alter ? shs_pkg::half_tz(s1_l_q - s1_r_q) : s1_l_q;
      side_q[2].mid <= shs_pkg::half_tz(s1_l_q) + shs_pkg::half_tz(s1_r_q);
    end
    // add the delayed low band
    if (can[3]) begin
      s3_x_q <= x0 + s2_dl_q;
    end
    // bass scaling
    if (can[4]) begin
      s4_x_q <= shs_pkg::fracmul(s3_x_q, cfg.bass);
    end
    // add delayed bass and high bands
    if (can[5]) begin
      s5_x_q <= s4_x_q + db_q[4] + dh_q[4];
    end
    // treble product
    if (can[6]) begin
      s6_x_q <= s5_x_q;
      s6_t_q <= shs_pkg::fracmul(s5_x_q, cfg.treble);
    end
    // subtract treble product, add delayed treble band
    if (can[7]) begin
      s7_x_q <= s6_x_q - s6_t_q + dt_q[6];
    end
    // magnitudes over 8
    if (can[8]) begin
      s8_x_q  <= s7_x_q;
      s8_ax_q <= mag_x[shs_pkg::DATA_W-1:3];
      s8_ay_q <= mag_y[shs_pkg::DATA_W-1:3];
    end
    // reciprocal multiply for the divide by 25
    if (can[9]) begin
      s9_x_q  <= s8_x_q;
      s9_qx_q <= prod_x[shs_pkg::RPROD_W-1 -: shs_pkg::QUOT_W];
      s9_qy_q <= prod_y[shs_pkg::RPROD_W-1 -: shs_pkg::QUOT_W];
    end
    // balance amounts
    if (can[10]) begin
      s10_x_q  <= s9_x_q;
      s10_mx_q <= qsx * $signed(32'(cfg.balance));
      s10_my_q <= qsy * $signed(32'(cfg.balance));
    end
    // output register
    if (can[NST]) begin
      out_l_q <= y_fin;
      out_r_q <= x_fin;
    end
  end

  // Carry side terms and delayed bands down the stages
  always_ff @(posedge clk_i) begin
    for (int i = 3; i <= 4; i++) begin
      if (can[i]) begin
        db_q[i] <= db_q[i-1];
        dh_q[i] <= dh_q[i-1];
      end
    end
    for (int i = 3; i <= 6; i++) begin
      if (can[i]) begin
        dt_q[i] <= dt_q[i-1];
      end
    end
    for (int i = 3; i <= 10; i++) begin
      if (can[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  `SHS_ASSERT(a_ready_when_drained, clk_i, rst_ni, (!out_valid_o) |-> in_ready_o, "input stalled with an empty output register")
  `SHS_ASSERT(a_pos_in_order, clk_i, rst_ni, (v_q[1] && v_q[2]) |-> (s1_pos_q == s2_pos_inc), "adjacent stages hold non-consecutive frames")
  `SHS_ASSERT(a_item_count, clk_i, rst_ni, $past(rst_ni) |-> ($countones(v_q) == $past($countones(v_q)) + $past(acc) - $past(out_fire)), "frame lost or duplicated in the pipeline")
  `SHS_ASSERT(a_fill_cap, clk_i, rst_ni, fill_q <= CNT_W'(MAX_DELAY_DEPTH), "fill count beyond store depth")

endmodule

### hdl/shs_delay_ram.sv
module shs_delay_ram #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [shs_pkg::DATA_W-1:0]    wr_data_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [shs_pkg::DATA_W-1:0]    rd_data_o
);

  logic [shs_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [shs_pkg::DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, new data forwarded on a same-edge write to the entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/shs_cfg_regs.sv
`include "stereo_haas_surround_macros.svh"

module shs_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [shs_pkg::APB_AW-1:0]  paddr,
  input  logic [shs_pkg::APB_DW-1:0]  pwdata,
  output logic [shs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output shs_pkg::cfg_t               cfg_o,
  output logic                        flush_o
);

  shs_pkg::cfg_t    cfg_q, cfg_d;
  shs_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = shs_pkg::reg_idx_e'(paddr[shs_pkg::APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Decode a register write
  always_comb begin
    cfg_d   = cfg_q;
    flush_o = 1'b0;
    if (wr) begin
      case (idx)
        shs_pkg::REG_LOW_CUT:  cfg_d.low_cut  = pwdata[shs_pkg::COEF_W-1:0];
        shs_pkg::REG_HIGH_CUT: cfg_d.high_cut = pwdata[shs_pkg::COEF_W-1:0];
        shs_pkg::REG_BASS:     cfg_d.bass     = pwdata[shs_pkg::COEF_W-1:0];
        shs_pkg::REG_TREBLE:   cfg_d.treble   = pwdata[shs_pkg::COEF_W-1:0];
        shs_pkg::REG_DELAY_SEL: begin
          flush_o = 1'b1;
          // keep the previous delay for a selector without meaning
          if ((pwdata[shs_pkg::SEL_W-1:0] >= shs_pkg::DSEL_91) &&
              (pwdata[shs_pkg::SEL_W-1:0] <= shs_pkg::DSEL_909)) begin
            cfg_d.delay_sel = pwdata[shs_pkg::SEL_W-1:0];
          end
        end
        shs_pkg::REG_BALANCE:  cfg_d.balance  = pwdata[shs_pkg::BAL_W-1:0];
        shs_pkg::REG_ALTER: begin
          flush_o     = 1'b1;
          cfg_d.alter = pwdata[0];
        end
        default: ;
      endcase
    end
  end

  // Hold the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= shs_pkg::CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      shs_pkg::REG_LOW_CUT:   prdata = {1'b0, cfg_q.low_cut};
      shs_pkg::REG_HIGH_CUT:  prdata = {1'b0, cfg_q.high_cut};
      shs_pkg::REG_BASS:      prdata = {1'b0, cfg_q.bass};
      shs_pkg::REG_TREBLE:    prdata = {1'b0, cfg_q.treble};
      shs_pkg::REG_DELAY_SEL: prdata = {29'd0, cfg_q.delay_sel};
      shs_pkg::REG_BALANCE:   prdata = {25'd0, cfg_q.balance};
      shs_pkg::REG_ALTER:     prdata = {31'd0, cfg_q.alter};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

  `SHS_ASSERT(a_dsel_range, clk_i, rst_ni, (cfg_q.delay_sel >= shs_pkg::DSEL_91) && (cfg_q.delay_sel <= shs_pkg::DSEL_909), "delay selector left its legal range")

endmodule

### tb/stereo_haas_surround_tb.sv
module stereo_haas_surround_tb;
  import shs_pkg::*;

  localparam int unsigned STORE_DEPTH   = MAX_DELAY_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = PIPE_STAGES + 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_PHASE    = 9;
  localparam int          BAL_RANDOM    = -1;

  localparam int S_MAX = 32'h7FFF_FFFF;
  localparam int S_MIN = 32'h8000_0000;

  // Selector codes that carry no delay
  localparam logic [SEL_W-1:0] DSEL_UNUSED_LO  = 3'd0;
  localparam logic [SEL_W-1:0] DSEL_UNUSED_MID = 3'd6;
  localparam logic [SEL_W-1:0] DSEL_UNUSED_HI  = 3'd7;

  // Band store indexes
  localparam int unsigned BAND_LOW    = 0;
  localparam int unsigned BAND_BASS   = 1;
  localparam int unsigned BAND_HIGH   = 2;
  localparam int unsigned BAND_TREBLE = 3;

  typedef enum int {ROW_FRAME, ROW_WRITE} row_kind_e;
  typedef enum int {COEF_RANDOM, COEF_MAX, COEF_ZERO} coef_kind_e;

  typedef struct {
    int left;
    int right;
  } frame_t;

  typedef struct {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [31:0] wdata;
    int          left;
    int          right;
    bit          typed;
    int          want_left;
    int          want_right;
  } dir_row_t;

  typedef struct {
    int               items;
    int               snd_pct;
    int               rcv_pct;
    coef_kind_e       coef_kind;
    int               bal;
    bit               wr_sel;
    logic [SEL_W-1:0] sel;
    bit               wr_alter;
    bit               alter;
  } phase_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  sample_t             left_in_i;
  sample_t             right_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  sample_t             left_out_o;
  sample_t             right_out_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  stereo_haas_surround #(
    .MAX_DELAY_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow copy of the block's registers and band stores
  bit [COEF_W-1:0] low_cut_r;
  bit [COEF_W-1:0] high_cut_r;
  bit [COEF_W-1:0] bass_r;
  bit [COEF_W-1:0] treble_r;
  bit [SEL_W-1:0]  dsel_r;
  bit [BAL_W-1:0]  bal_r;
  bit              alter_r;
  int              band_store [4][STORE_DEPTH];
  int unsigned     band_depth [4] = '{STORE_DEPTH / 8, STORE_DEPTH / 4, STORE_DEPTH,
                                      STORE_DEPTH / 2};
  int unsigned     write_pos;

  frame_t expected_frames [$];
  frame_t head_frame;
  int     mismatch_count = 0;
  int     snd_idle_pct   = 0;
  int     rcv_idle_pct   = 0;
  int     hold_left      = 0;

  dir_row_t directed_rows [25] = '{
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          0,           0,           1'b1, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MAX,       0,           1'b1, S_MAX, 0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MIN,       0,           1'b1, S_MIN, 0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          -1,          0,           1'b1, -1,    0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          0,           S_MAX,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          0,           S_MIN,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MAX,       S_MAX,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MIN,       S_MIN,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MAX,       S_MIN,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MIN,       S_MAX,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          32'h55555555, 32'hAAAAAAAA, 1'b0, 0,   0},
    '{ROW_WRITE, REG_ALTER,     32'd1,          0,           0,           1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MIN,       S_MAX,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MAX,       S_MIN,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          -1,          1,           1'b0, 0,     0},
    '{ROW_WRITE, REG_BALANCE,   32'd127,        0,           0,           1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MIN,       S_MIN,       1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MAX,       -S_MAX,      1'b0, 0,     0},
    '{ROW_WRITE, REG_DELAY_SEL, {29'd0, DSEL_UNUSED_LO}, 0,  0,           1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          12345,       -6789,       1'b0, 0,     0},
    '{ROW_WRITE, REG_DELAY_SEL, {29'd0, DSEL_UNUSED_MID}, 0, 0,           1'b0, 0,     0},
    '{ROW_WRITE, REG_ALTER,     32'd0,          0,           0,           1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          0,           0,           1'b1, 0,     0},
    '{ROW_WRITE, REG_BALANCE,   32'd0,          0,           0,           1'b0, 0,     0},
    '{ROW_FRAME, REG_LOW_CUT,   32'd0,          S_MAX,       0,           1'b1, S_MAX, 0}
  };

  phase_t phases [11] = '{
    '{110, 30, 75, COEF_RANDOM, 0,          1'b1, DSEL_91,        1'b1, 1'b0},
    '{110, 30, 75, COEF_MAX,    100,        1'b0, DSEL_91,        1'b0, 1'b0},
    '{110, 30, 75, COEF_RANDOM, 127,        1'b1, DSEL_182,       1'b1, 1'b1},
    '{110, 30, 75, COEF_ZERO,   1,          1'b1, DSEL_UNUSED_HI, 1'b0, 1'b0},
    '{110, 75, 30, COEF_RANDOM, BAL_RANDOM, 1'b1, DSEL_454,       1'b1, 1'b0},
    '{110, 75, 30, COEF_RANDOM, BAL_RANDOM, 1'b0, DSEL_454,       1'b0, 1'b0},
    '{110, 75, 30, COEF_RANDOM, BAL_RANDOM, 1'b1, DSEL_727,       1'b1, 1'b1},
    '{110, 75, 30, COEF_MAX,    50,         1'b0, DSEL_727,       1'b0, 1'b0},
    '{330, 0,  0,  COEF_RANDOM, 0,          1'b1, DSEL_909,       1'b1, 1'b0},
    '{330, 0,  0,  COEF_RANDOM, BAL_RANDOM, 1'b0, DSEL_909,       1'b0, 1'b0},
    '{330, 0,  0,  COEF_RANDOM, BAL_RANDOM, 1'b0, DSEL_909,       1'b0, 1'b0}
  };

  // Signed Q31 product, floored
  function automatic int q31_mul(input int a, input bit [COEF_W-1:0] c);
    longint p;
    p = longint'(a) * longint'({33'd0, c});
    return int'(p >>> 31);
  endfunction

  function automatic void clear_bands();
    foreach (band_store[i, j]) band_store[i][j] = 0;
  endfunction

  // Read the term written d frames ago, then store the new one
  function automatic int band_tap(input int unsigned band, input int unsigned d, input int v);
    int unsigned depth;
    int unsigned wr;
    int unsigned rd;
    int          old;
    depth = band_depth[band];
    if (depth == 0 || d == 0) return v;
    if (d > depth) d = depth;
    wr  = write_pos % depth;
    rd  = (wr + depth - d) % depth;
    old = band_store[band][rd];
    band_store[band][wr] = v;
    return old;
  endfunction

  function automatic int unsigned delay_samples();
    case (dsel_r)
      DSEL_91:  return 91;
      DSEL_182: return 182;
      DSEL_454: return 454;
      DSEL_727: return 727;
      default:  return 909;
    endcase
  endfunction

  // Compute the processed frame and advance the shadow state
  function automatic void haas_predict(input int l, input int r, output int yl, output int xr);
    int unsigned d;
    int          mid;
    int          diff;
    int          n;
    int          b;
    int          y;
    int          x;
    d = delay_samples();
    if (d > STORE_DEPTH) d = STORE_DEPTH;
    mid  = l / 2 + r / 2;
    diff = l - r;
    if (!alter_r) begin
      y = l;
      x = q31_mul(r, low_cut_r) - q31_mul(r, high_cut_r);
    end else begin
      n = -diff;
      y = diff / 2;
      x = q31_mul(n, low_cut_r) / 2 - q31_mul(n, high_cut_r) / 2;
    end
    x = x + band_tap(BAND_LOW, d / 8, r - q31_mul(r, low_cut_r));
    x = q31_mul(x, bass_r);
    x = x + band_tap(BAND_BASS, d / 4, r - q31_mul(r, bass_r));
    x = x + band_tap(BAND_HIGH, d, q31_mul(r, high_cut_r));
    x = x - q31_mul(x, treble_r);
    x = x + band_tap(BAND_TREBLE, d / 2, q31_mul(r, treble_r));
    if (bal_r != 0) begin
      b = int'({25'd0, bal_r});
      if (!alter_r) begin
        y = y - (y / 200) * b;
        x = x + (x / 200) * b;
      end else begin
        y = y + (y / 200) * b;
        x = x - (x / 200) * b;
      end
    end
    if (alter_r) begin
      y = y + mid;
      x = x + mid;
    end
    write_pos = (write_pos + 1) % STORE_DEPTH;
    yl = y;
    xr = x;
  endfunction

  // Mirror a register write into the shadow state
  function automatic void apply_write(input reg_idx_e idx, input logic [31:0] v);
    case (idx)
      REG_LOW_CUT:  low_cut_r  = v[COEF_W-1:0];
      REG_HIGH_CUT: high_cut_r = v[COEF_W-1:0];
      REG_BASS:     bass_r     = v[COEF_W-1:0];
      REG_TREBLE:   treble_r   = v[COEF_W-1:0];
      REG_DELAY_SEL: begin
        clear_bands();
        if (v[SEL_W-1:0] >= DSEL_91 && v[SEL_W-1:0] <= DSEL_909) dsel_r = v[SEL_W-1:0];
      end
      REG_BALANCE:  bal_r = v[BAL_W-1:0];
      REG_ALTER: begin
        clear_bands();
        alter_r = v[0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] coef_word(input coef_kind_e kind);
    case (kind)
      COEF_MAX:  return 32'hFFFF_FFFF;
      COEF_ZERO: return 32'd0;
      default:   return $urandom;
    endcase
  endfunction

  // Mostly full-range samples, with extremes and quiet passages mixed in
  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offer one frame, with an optional gap, and log its expectation on transfer
  task automatic offer_frame(input int l, input int r, input bit typed, input int tl,
                             input int tr);
    int gap;
    int pl;
    int pr;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    haas_predict(l, r, pl, pr);
    if (typed) expected_frames.push_back('{tl, tr});
    else expected_frames.push_back('{pl, pr});
  endtask

  // Drop valid and let the pipeline empty out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Setup then access cycle on the register port
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_write(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected frame, left", left_out_o, 0);
      end else begin
        head_frame = expected_frames.pop_front();
        if (left_out_o !== head_frame.left)
          report_mismatch("left_out", left_out_o, head_frame.left);
        if (right_out_o !== head_frame.right)
          report_mismatch("right_out", right_out_o, head_frame.right);
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned ph;
    int unsigned k;
    int          bal;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    left_in_i  = '0;
    right_in_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    low_cut_r  = CFG_RST.low_cut;
    high_cut_r = CFG_RST.high_cut;
    bass_r     = CFG_RST.bass;
    treble_r   = CFG_RST.treble;
    dsel_r     = CFG_RST.delay_sel;
    bal_r      = CFG_RST.balance;
    alter_r    = CFG_RST.alter;
    clear_bands();
    write_pos  = 0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: extremes, both methods, odd selectors and balance
    snd_idle_pct = 30;
    rcv_idle_pct = 75;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        offer_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].typed,
                    directed_rows[i].want_left, directed_rows[i].want_right);
      end
    end

    // Random phases, each under its own register setting
    for (ph = 0; ph < $size(phases); ph++) begin
      wait_drained();
      snd_idle_pct = phases[ph].snd_pct;
      rcv_idle_pct = phases[ph].rcv_pct;
      write_reg(REG_LOW_CUT,  coef_word(phases[ph].coef_kind));
      write_reg(REG_HIGH_CUT, coef_word(phases[ph].coef_kind));
      write_reg(REG_BASS,     coef_word(phases[ph].coef_kind));
      write_reg(REG_TREBLE,   coef_word(phases[ph].coef_kind));
      bal = (phases[ph].bal == BAL_RANDOM) ? $urandom_range(0, 127) : phases[ph].bal;
      write_reg(REG_BALANCE, ($urandom & ~32'h7F) | bal);
      if (phases[ph].wr_sel)
        write_reg(REG_DELAY_SEL, ($urandom & ~32'h7) | phases[ph].sel);
      if (phases[ph].wr_alter)
        write_reg(REG_ALTER, ($urandom & ~32'h1) | phases[ph].alter);
      if (ph == HOLD_PHASE) hold_left = HOLD_CYCLES;
      for (k = 0; k < phases[ph].items; k++)
        offer_frame(rand_sample(), rand_sample(), 1'b0, 0, 0);
    end

    wait_drained();
    repeat (2 * PIPE_STAGES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
